/* hdl/b64d_pkg.sv */
`default_nettype none
package b64d_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_in;
        logic       msg_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            msg_end;
    } t_job;

    typedef struct packed {
        logic       halted;
        logic [1:0] group_count;
    } t_front_stat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

/* hdl/b64d_front.sv */
`default_nettype none
module b64d_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  b64d_pkg::t_in_item    i_item,
    output logic                  o_push,
    output b64d_pkg::t_job        o_job,
    output b64d_pkg::t_front_stat o_stat
);
    import b64d_pkg::*;

    localparam logic [6:0] NO_SEXTET = 7'd64;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        s = NO_SEXTET;
        if (c >= 8'h41 && c <= 8'h5a) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            s = 7'd62;
        end else if (c == 8'h2f) begin
            s = 7'd63;
        end
        return s;
    endfunction

    function automatic logic [2:0][7:0] pack_bytes(input logic [5:0] s0, input logic [5:0] s1,
                                                    input logic [5:0] s2, input logic [5:0] s3);
        logic [2:0][7:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        return b;
    endfunction

    logic [2:0][5:0] r_store, n_store;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_halt, n_halt;
    logic [6:0]      sx;
    logic [5:0]      s2_flush;
    t_job            job;

    always_comb begin
        sx       = sextet_of(i_item.char_in);
        n_store  = r_store;
        n_cnt    = r_cnt;
        n_halt   = r_halt;
        job      = '0;
        s2_flush = '0;
        if (!r_halt) begin
            if (sx[6]) begin
                n_halt = 1'b1;
            end else if (r_cnt == 2'd3) begin
                job.bytes = pack_bytes(r_store[0], r_store[1], r_store[2], sx[5:0]);
                job.count = 2'd3;
                n_cnt     = 2'd0;
            end else begin
                unique case (r_cnt)
                    2'd0:    n_store[0] = sx[5:0];
                    2'd1:    n_store[1] = sx[5:0];
                    default: n_store[2] = sx[5:0];
                endcase
                n_cnt = r_cnt + 2'd1;
            end
        end
        if (i_item.msg_last) begin
            if (n_cnt > 2'd1) begin
                s2_flush  = (n_cnt == 2'd3) ? n_store[2] : 6'd0;
                job.bytes = pack_bytes(n_store[0], n_store[1], s2_flush, 6'd0);
                job.count = n_cnt - 2'd1;
            end
            job.msg_end = 1'b1;
            n_store     = '0;
            n_cnt       = 2'd0;
            n_halt      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_cnt   <= 2'd0;
            r_halt  <= 1'b0;
        end else if (i_accept) begin
            r_store <= n_store;
            r_cnt   <= n_cnt;
            r_halt  <= n_halt;
        end
    end

    assign o_push             = i_accept && (job.count != 2'd0);
    assign o_job              = job;
    assign o_stat.halted      = r_halt;
    assign o_stat.group_count = r_cnt;

endmodule
`default_nettype wire

/* hdl/b64d_queue.sv */
`default_nettype none
module b64d_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  b64d_pkg::t_job    i_job,
    input  wire               i_pop,
    output logic              o_valid,
    output b64d_pkg::t_job    o_job,
    output b64d_pkg::t_q_stat o_stat
);
    import b64d_pkg::*;

    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_valid      = !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/b64d_back.sv */
`default_nettype none
module b64d_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  b64d_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output b64d_pkg::t_out_item o_out_data
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_out;
    logic       load, last_b;

    assign load   = i_q_valid && (!r_valid || !i_out_stall);
    assign last_b = (r_idx == i_job.count - 2'd1);
    assign o_pop  = load && last_b;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.byte_out    <= i_job.bytes[r_idx];
            r_out.run_last    <= last_b;
            r_out.message_end <= last_b && i_job.msg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_b ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* hdl/base64_stream_decoder.sv */
// Each decoded byte passes through the job queue and then the output register.
// One character per cycle unless stalled; a full group gives three bytes at that rate.
// A four-entry job queue between the decode front and the byte sequencer stalls the
// input only when it fills, which a sustained stall on the output causes.
// Reset (i_rst_n low, synchronous) empties the queue and clears the group state.
`default_nettype none
module base64_stream_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  b64d_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output b64d_pkg::t_out_item o_out_data
);
    import b64d_pkg::*;

    logic        accept, push, q_valid, pop;
    t_job        f_job, q_job;
    t_front_stat f_stat;
    t_q_stat     q_stat;

    assign o_in_stall = q_stat.full;
    assign accept     = i_in_valid && !q_stat.full;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_data),
        .o_push  (push),
        .o_job   (f_job),
        .o_stat  (f_stat)
    );

    b64d_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (f_job),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job),
        .o_stat (q_stat)
    );

    b64d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    a_msg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.msg_last |=> !f_stat.halted && f_stat.group_count == 2'd0)
        else $error("group state not cleared after end of message");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid && !q_stat.empty)
        else $error("pop from empty job queue");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.message_end |-> o_out_data.run_last)
        else $error("message end on a byte that does not close its transaction");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !push)
        else $error("job pushed into a full queue");

endmodule
`default_nettype wire
